// ===== rtl/core/ipv4p_pkg.sv =====
`timescale 1ns / 1ps

package ipv4p_pkg;

    typedef logic [2:0]  phase_t;
    typedef logic [1:0]  radix_t;
    typedef logic [31:0] word_t;

    localparam phase_t PH_START  = 3'd0;
    localparam phase_t PH_ZERO   = 3'd1;
    localparam phase_t PH_DIGITS = 3'd2;
    localparam phase_t PH_OK     = 3'd3;
    localparam phase_t PH_BAD    = 3'd4;

    localparam radix_t RX_DEC = 2'd0;
    localparam radix_t RX_OCT = 2'd1;
    localparam radix_t RX_HEX = 2'd2;

    localparam word_t LIMIT_24 = 32'h00ff_ffff;
    localparam word_t LIMIT_16 = 32'h0000_ffff;
    localparam word_t LIMIT_8  = 32'h0000_00ff;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_DOT = 8'h2e;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_X   = 8'h58;
    localparam logic [7:0] CH_LX  = 8'h78;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_F   = 8'h46;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LF  = 8'h66;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0d;

    localparam logic [1:0] MAX_EARLIER = 2'd3;

endpackage

// ===== rtl/core/ipv4_dotted_address_parser_top.sv =====
`timescale 1ns / 1ps
// A zero byte is first registered in the input register and parsed from there; the result of a
// string is presented at the edge at which that byte is parsed, which an output stall can delay.
// Throughput: one character per cycle; a zero byte waits
// only while an earlier result is still held in the result register.
// Reset (aresetn low, synchronous) empties both registers and returns the parser to the
// start of a string; the stored earlier parts are not cleared.

module ipv4_dotted_address_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output ipv4p_pkg::word_t m_address
);

    import ipv4p_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_ch_reg;

    phase_t phase_reg, phase_next;
    word_t  part_reg, part_next;
    radix_t radix_reg, radix_next;
    logic [1:0] done_reg, done_next;
    word_t  earlier_reg [3];

    logic   out_valid_reg, out_valid_next;
    logic   out_res_reg, out_res_next;
    word_t  out_addr_reg, out_addr_next;

    logic   is_end, advance, emit, store_part;
    logic   fin_ok;
    word_t  fin_val;

    assign is_end  = (in_ch_reg == CH_NUL);
    assign advance = in_valid_reg && (!is_end || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign m_valid     = out_valid_reg;
    assign m_valid_res = out_res_reg;
    assign m_address   = out_addr_reg;

    always_comb begin
        fin_ok  = 1'b1;
        fin_val = part_reg;
        case (done_reg)
            2'd0: begin
                fin_val = part_reg;
            end
            2'd1: begin
                fin_ok  = (part_reg <= LIMIT_24);
                fin_val = part_reg | (earlier_reg[0] << 24);
            end
            2'd2: begin
                fin_ok  = (part_reg <= LIMIT_16);
                fin_val = part_reg | (earlier_reg[0] << 24) | (earlier_reg[1] << 16);
            end
            default: begin
                fin_ok  = (part_reg <= LIMIT_8);
                fin_val = part_reg | (earlier_reg[0] << 24) | (earlier_reg[1] << 16)
                        | (earlier_reg[2] << 8);
            end
        endcase
    end

    always_comb begin
        radix_t     eff_radix;
        logic       is_dig, is_hex_lc, is_hex_uc, is_sp;
        word_t      scaled;
        logic [3:0] letter;
        eff_radix = (phase_reg == PH_ZERO) ? RX_OCT : radix_reg;
        is_dig    = (in_ch_reg inside {[CH_0:CH_9]});
        is_hex_lc = (in_ch_reg inside {[CH_LA:CH_LF]});
        is_hex_uc = (in_ch_reg inside {[CH_A:CH_F]});
        is_sp     = (in_ch_reg == CH_SP) || (in_ch_reg inside {[CH_TAB:CH_CR]});
        letter    = {1'b0, in_ch_reg[2:0]} + 4'd9;
        case (eff_radix)
            RX_HEX:  scaled = part_reg << 4;
            RX_OCT:  scaled = part_reg << 3;
            default: scaled = (part_reg << 3) + (part_reg << 1);
        endcase

        phase_next = phase_reg;
        part_next  = part_reg;
        radix_next = radix_reg;
        done_next  = done_reg;
        emit       = 1'b0;
        store_part = 1'b0;
        out_res_next  = 1'b0;
        out_addr_next = '0;

        case (phase_reg)
            PH_ZERO, PH_DIGITS: begin
                if (phase_reg == PH_ZERO && (in_ch_reg == CH_X || in_ch_reg == CH_LX)) begin
                    radix_next = RX_HEX;
                    phase_next = PH_DIGITS;
                end else begin
                    radix_next = eff_radix;
                    phase_next = PH_DIGITS;
                    if (is_dig) begin
                        part_next = scaled + {28'd0, in_ch_reg[3:0]};
                    end else if (eff_radix == RX_HEX && (is_hex_lc || is_hex_uc)) begin
                        part_next = scaled | {28'd0, letter};
                    end else if (in_ch_reg == CH_DOT) begin
                        if (done_reg == MAX_EARLIER) begin
                            phase_next = PH_BAD;
                            part_next  = '0;
                        end else begin
                            store_part = 1'b1;
                            done_next  = done_reg + 2'd1;
                            part_next  = '0;
                            radix_next = RX_DEC;
                            phase_next = PH_START;
                        end
                    end else if (is_end) begin
                        emit          = 1'b1;
                        out_res_next  = fin_ok;
                        out_addr_next = fin_ok ? fin_val : '0;
                    end else if (is_sp) begin
                        phase_next = fin_ok ? PH_OK : PH_BAD;
                        part_next  = fin_ok ? fin_val : '0;
                    end else begin
                        phase_next = PH_BAD;
                        part_next  = '0;
                    end
                end
            end
            PH_OK: begin
                if (is_end) begin
                    emit          = 1'b1;
                    out_res_next  = 1'b1;
                    out_addr_next = part_reg;
                end
            end
            PH_BAD: begin
                emit = is_end;
            end
            default: begin
                if (is_end) begin
                    emit = 1'b1;
                end else if (!is_dig) begin
                    phase_next = PH_BAD;
                    part_next  = '0;
                end else if (in_ch_reg == CH_0) begin
                    phase_next = PH_ZERO;
                    part_next  = '0;
                end else begin
                    radix_next = RX_DEC;
                    part_next  = {28'd0, in_ch_reg[3:0]};
                    phase_next = PH_DIGITS;
                end
            end
        endcase

        if (emit) begin
            phase_next = PH_START;
            part_next  = '0;
            radix_next = RX_DEC;
            done_next  = 2'd0;
        end

        if (advance && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            part_reg      <= '0;
            radix_reg     <= RX_DEC;
            done_reg      <= 2'd0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg <= phase_next;
                part_reg  <= part_next;
                radix_reg <= radix_next;
                done_reg  <= done_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_ch_reg <= s_ch;
        end
        if (advance && store_part) begin
            earlier_reg[done_reg] <= part_reg;
        end
        if (advance && emit) begin
            out_res_reg  <= out_res_next;
            out_addr_reg <= out_addr_next;
        end
    end

endmodule

// ===== sim/tb_ipv4_dotted_address_parser_top.sv =====
`timescale 1ns / 1ps

module tb_ipv4_dotted_address_parser_top;
    import ipv4p_pkg::*;

    localparam int ITEM_TARGET = 1250;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic  ok;
        word_t addr;
    } parse_result_t;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_MOSTLY,
        READY_THIRDS
    } ready_mode_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_ch = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_valid_res;
    word_t      m_address;

    logic [7:0]    pending_chars[$];
    logic [7:0]    draft[$];
    parse_result_t expected_addresses[$];
    parse_result_t want;
    int            error_count = 0;

    phase_t     scan_phase = PH_START;
    word_t      part_acc = '0;
    radix_t     part_radix = RX_DEC;
    logic [1:0] dots_seen = 2'd0;
    word_t      prior_parts[3];

    int          burst_left = 0;
    int          gap_left = 0;
    ready_mode_t ready_mode = READY_ALWAYS;
    int          ready_span = 0;
    int          ready_tick = 0;

    ipv4_dotted_address_parser_top dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ch       (s_ch),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_valid_res(m_valid_res),
        .m_address  (m_address)
    );

    always #4 aclk = ~aclk;

    function automatic bit is_dec(logic [7:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    task automatic report_mismatch(string what, logic [32:0] expected_val, logic [32:0] got);
        $display("%0t mismatch on %s: expected %h, got %h", $time, what, expected_val, got);
        error_count++;
    endtask

    task automatic post_address(logic ok, word_t addr);
        parse_result_t r;
        r.ok = ok;
        r.addr = ok ? addr : '0;
        expected_addresses.push_back(r);
        scan_phase = PH_START;
        part_acc = '0;
        part_radix = RX_DEC;
        dots_seen = 2'd0;
    endtask

    task automatic close_address();
        word_t v;
        logic  ok;
        v = part_acc;
        ok = 1'b1;
        case (dots_seen)
            2'd0: ;
            2'd1: begin
                if (v > LIMIT_24) ok = 1'b0;
                else v |= prior_parts[0] << 24;
            end
            2'd2: begin
                if (v > LIMIT_16) ok = 1'b0;
                else v |= (prior_parts[0] << 24) | (prior_parts[1] << 16);
            end
            default: begin
                if (v > LIMIT_8) ok = 1'b0;
                else v |= (prior_parts[0] << 24) | (prior_parts[1] << 16) | (prior_parts[2] << 8);
            end
        endcase
        if (ok) begin
            part_acc = v;
            scan_phase = PH_OK;
        end else begin
            part_acc = '0;
            scan_phase = PH_BAD;
        end
    endtask

    task automatic step_part(logic [7:0] c);
        word_t      mul;
        logic [7:0] nib;
        mul = (part_radix == RX_HEX) ? 32'd16 : (part_radix == RX_OCT) ? 32'd8 : 32'd10;
        if (is_dec(c)) begin
            part_acc = part_acc * mul + word_t'(c - CH_0);
            scan_phase = PH_DIGITS;
        end else if (part_radix == RX_HEX
                     && ((c >= CH_LA && c <= CH_LF) || (c >= CH_A && c <= CH_F))) begin
            nib = (c >= CH_LA) ? c - CH_LA + 8'd10 : c - CH_A + 8'd10;
            part_acc = (part_acc << 4) | word_t'(nib[3:0]);
            scan_phase = PH_DIGITS;
        end else if (c == CH_DOT) begin
            if (dots_seen >= MAX_EARLIER) begin
                scan_phase = PH_BAD;
                part_acc = '0;
            end else begin
                prior_parts[dots_seen] = part_acc;
                dots_seen++;
                part_acc = '0;
                part_radix = RX_DEC;
                scan_phase = PH_START;
            end
        end else if (c == CH_NUL) begin
            close_address();
            post_address(scan_phase == PH_OK, part_acc);
        end else if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) begin
            close_address();
        end else begin
            scan_phase = PH_BAD;
            part_acc = '0;
        end
    endtask

    task automatic parse_char(logic [7:0] c);
        case (scan_phase)
            PH_ZERO: begin
                part_radix = (c == CH_X || c == CH_LX) ? RX_HEX : RX_OCT;
                scan_phase = PH_DIGITS;
                if (part_radix == RX_OCT) step_part(c);
            end
            PH_DIGITS: step_part(c);
            PH_OK: if (c == CH_NUL) post_address(1'b1, part_acc);
            PH_BAD: if (c == CH_NUL) post_address(1'b0, '0);
            default: begin
                if (c == CH_NUL) begin
                    post_address(1'b0, '0);
                end else if (!is_dec(c)) begin
                    scan_phase = PH_BAD;
                    part_acc = '0;
                end else if (c == CH_0) begin
                    part_acc = '0;
                    scan_phase = PH_ZERO;
                end else begin
                    part_radix = RX_DEC;
                    part_acc = word_t'(c - CH_0);
                    scan_phase = PH_DIGITS;
                end
            end
        endcase
    endtask

    function automatic word_t pick_part(bit last, int nparts);
        word_t lim;
        lim = LIMIT_8;
        if (last) begin
            case (nparts)
                1: lim = 32'hffff_ffff;
                2: lim = LIMIT_24;
                3: lim = LIMIT_16;
                default: lim = LIMIT_8;
            endcase
        end
        case ($urandom_range(0, 5))
            0: return '0;
            1: return lim;
            2: return lim + 32'd1;
            3: return $urandom;
            default: return $urandom_range(0, lim);
        endcase
    endfunction

    task automatic put_value(word_t v, radix_t r);
        logic [7:0] digits[$];
        logic [7:0] nib;
        int         extra;
        if (r == RX_OCT) begin
            draft.push_back(CH_0);
            extra = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 13) : $urandom_range(0, 4);
            repeat (extra) digits.push_back(8'(CH_0 + $urandom_range(0, 9)));
        end else if (r == RX_HEX) begin
            draft.push_back(CH_0);
            draft.push_back($urandom_range(0, 1) ? CH_X : CH_LX);
            if (v != 0 || $urandom_range(0, 1)) begin
                do begin
                    nib = {4'd0, v[3:0]};
                    if (nib < 8'd10) digits.push_front(CH_0 + nib);
                    else digits.push_front(($urandom_range(0, 1) ? CH_A : CH_LA) + nib - 8'd10);
                    v = v >> 4;
                end while (v != 0);
            end
        end else begin
            do begin
                digits.push_front(8'(CH_0 + v % 10));
                v = v / 10;
            end while (v != 0);
        end
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) digits.push_back(8'(CH_0 + $urandom_range(0, 9)));
        end
        foreach (digits[i]) draft.push_back(digits[i]);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) pending_chars.push_back(s[i]);
        pending_chars.push_back(CH_NUL);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_ch <= CH_NUL;
        end else begin
            if (s_valid && s_ready) parse_char(s_ch);
            if (!s_valid || s_ready) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                if (burst_left > 0 && pending_chars.size() > 0) begin
                    s_valid <= 1'b1;
                    s_ch <= pending_chars.pop_front();
                    burst_left--;
                end else begin
                    s_valid <= 1'b0;
                    if (burst_left > 0) burst_left = 0;
                    else if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_addresses.size() == 0) begin
                    report_mismatch("unexpected result", '0, {m_valid_res, m_address});
                end else begin
                    want = expected_addresses.pop_front();
                    if (m_valid_res !== want.ok) begin
                        report_mismatch("valid_res", {32'd0, want.ok}, {32'd0, m_valid_res});
                    end
                    if (m_address !== want.addr) begin
                        report_mismatch("address", {1'b0, want.addr}, {1'b0, m_address});
                    end
                end
            end
            if (ready_span == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                ready_span = $urandom_range(16, 96);
            end
            ready_span--;
            ready_tick++;
            case (ready_mode)
                READY_ALWAYS: m_ready <= 1'b1;
                READY_COIN: m_ready <= 1'($urandom_range(0, 1));
                READY_MOSTLY: m_ready <= ($urandom_range(0, 4) != 0);
                default: m_ready <= (ready_tick % 3 == 0);
            endcase
        end
    end

    initial begin
        int kind;
        int nparts;
        int pos;
        int ws;
        add_text("");
        add_text("\377");
        add_text("0x.08\t?");
        add_text("1.2.3.4.");
        add_text("1..2");
        add_text("9g");
        add_text(" 7");
        while (pending_chars.size() < ITEM_TARGET) begin
            draft.delete();
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                nparts = $urandom_range(1, 4);
                for (int p = 0; p < nparts; p++) begin
                    if (p != 0) draft.push_back(CH_DOT);
                    put_value(pick_part(p == nparts - 1, nparts), radix_t'($urandom_range(0, 2)));
                end
                if ($urandom_range(0, 3) == 0) begin
                    ws = $urandom_range(0, 5);
                    draft.push_back((ws == 5) ? CH_SP : 8'(CH_TAB + ws));
                    repeat ($urandom_range(0, 3)) draft.push_back(8'($urandom_range(1, 255)));
                end
                if (kind == 7) begin
                    pos = $urandom_range(0, draft.size() - 1);
                    case ($urandom_range(0, 2))
                        0: draft[pos] = 8'($urandom_range(1, 255));
                        1: draft.insert(pos, CH_DOT);
                        default: draft.push_back(CH_DOT);
                    endcase
                end
            end else begin
                repeat ($urandom_range(0, 8)) draft.push_back(8'($urandom_range(1, 255)));
            end
            draft.push_back(CH_NUL);
            foreach (draft[i]) pending_chars.push_back(draft[i]);
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_chars.size() != 0 || s_valid || expected_addresses.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
